// ----- rtl/core/ber_tlv_stream_parser_macros.svh -----
// assertion macros for the ber tlv stream parser
// used by the top level; expects clk and rst_n in scope
`ifndef BER_TLV_STREAM_PARSER_MACROS_SVH
`define BER_TLV_STREAM_PARSER_MACROS_SVH
`ifndef ASSERT_OFF
`define BTLV_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("btlv assertion failed");
`define BTLV_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("btlv forbidden condition seen");
`else
`define BTLV_ASSERT(label, prop)
`define BTLV_NEVER(label, cond)
`endif
`endif

// ----- rtl/core/btlv_pkg.sv -----
// shared types and constants of the ber tlv stream parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package btlv_pkg;

    localparam int MAX_DEPTH = 8;
    localparam int TAG_BITS  = 16;
    localparam int DEPTH_W   = 4;
    localparam int IDX_W     = 3;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;
    localparam logic [2:0] LEN_OCT_LIMIT = 3'd4;
    localparam logic [2:0] LEN_OCT_RESET = 3'd4;

    typedef enum logic [1:0] {
        EV_HEADER  = 2'd0,
        EV_CONTENT = 2'd1,
        EV_END     = 2'd2,
        EV_ERROR   = 2'd3
    } ev_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_TAG_OVF  = 3'd1,
        ERR_LEN_LONG = 3'd2,
        ERR_IND_PRIM = 3'd3,
        ERR_OVERRUN  = 3'd4,
        ERR_DEEP     = 3'd5
    } err_code_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       frame_start;
    } btlv_in_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [1:0]  tag_class;
        logic        constructed;
        logic [15:0] tag_number;
        logic [31:0] content_length;
        logic        indefinite;
        logic [3:0]  nest_level;
        logic [7:0]  data_byte;
        logic [2:0]  error_code;
        logic        last;
    } btlv_out_t;

    typedef struct packed {
        logic full;
        logic empty;
    } btlv_qstat_t;

    typedef struct packed {
        logic               busy;
        logic [DEPTH_W-1:0] depth;
    } btlv_fstat_t;

    // ind marks an indefinite level; pos is the end of the innermost definite level
    typedef struct packed {
        logic        ind;
        logic        has_lim;
        logic [31:0] pos;
    } btlv_stk_t;

endpackage

`default_nettype wire

// ----- rtl/core/btlv_front.sv -----
// front part: accepts bytes, decodes identifier and length, keeps the nesting stack
// and queues events; depends on btlv_pkg
`timescale 1ns / 1ps
`default_nettype none

module btlv_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire btlv_pkg::btlv_in_t    in_data,
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_wdata,
    input  wire btlv_pkg::btlv_qstat_t q_stat,
    output logic                       q_push,
    output btlv_pkg::btlv_out_t        q_wdata,
    output btlv_pkg::btlv_fstat_t      f_stat
);
    import btlv_pkg::*;

    typedef enum logic [4:0] {
        F_IDLE  = 5'b00001,
        F_EXEC  = 5'b00010,
        F_END   = 5'b00100,
        F_CASC  = 5'b01000,
        F_FLUSH = 5'b10000
    } fstate_t;

    typedef enum logic [4:0] {
        PH_IDENT = 5'b00001,
        PH_TAGX  = 5'b00010,
        PH_LEN   = 5'b00100,
        PH_LENX  = 5'b01000,
        PH_DATA  = 5'b10000
    } phase_t;

    function automatic btlv_out_t mk_ev(logic [1:0] kind, logic [1:0] cls, logic cons,
                                        logic [TAG_BITS-1:0] tag, logic [31:0] clen,
                                        logic ind, logic [DEPTH_W-1:0] lvl,
                                        logic [7:0] data, logic [2:0] code);
        btlv_out_t e;
        e.event_kind     = kind;
        e.tag_class      = cls;
        e.constructed    = cons;
        e.tag_number     = tag;
        e.content_length = clen;
        e.indefinite     = ind;
        e.nest_level     = lvl;
        e.data_byte      = data;
        e.error_code     = code;
        e.last           = 1'b0;
        return e;
    endfunction

    fstate_t             state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [7:0]          byte_reg, byte_next;
    logic [1:0]          class_reg, class_next;
    logic                cons_reg, cons_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [31:0]         lacc_reg, lacc_next;
    logic [2:0]          lleft_reg, lleft_next;
    logic [31:0]         cleft_reg, cleft_next;
    logic [31:0]         bc_reg, bc_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic                err_reg, err_next;
    logic [2:0]          cfg_reg;
    logic                pend_valid_reg, pend_valid_next;
    btlv_out_t           pend_reg, pend_next;
    logic [DEPTH_W-1:0]  lvl_reg, lvl_next;

    btlv_stk_t           stack_mem [MAX_DEPTH];
    logic                stk_we;
    btlv_stk_t           stk_wdata;

    btlv_stk_t           top;
    logic                depth_nz;
    logic                has_lim;
    logic                casc_ok;
    logic [31:0]         bc_inc;
    logic                hd_go;
    logic                hd_indef;
    logic [31:0]         hd_len;
    logic                fail_go;
    logic [2:0]          fail_code;
    logic [TAG_BITS-1:0] tag_or;
    logic [31:0]         lacc_shift;
    logic [2:0]          lim_oct;

    assign depth_nz = depth_reg != '0;
    assign top      = stack_mem[IDX_W'(depth_reg - 1'b1)];
    assign has_lim  = depth_nz && top.has_lim;
    // innermost level is definite and ends exactly here
    assign casc_ok  = depth_nz && !top.ind && (top.pos == bc_reg);
    assign bc_inc   = bc_reg + 32'd1;
    assign tag_or   = tag_reg | TAG_BITS'(byte_reg[6:0]);
    assign lacc_shift = {lacc_reg[23:0], byte_reg};
    assign lim_oct  = (cfg_reg > LEN_OCT_LIMIT) ? LEN_OCT_LIMIT : cfg_reg;

    assign f_stat.busy  = state_reg != F_IDLE;
    assign f_stat.depth = depth_reg;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        byte_next       = byte_reg;
        class_next      = class_reg;
        cons_next       = cons_reg;
        tag_next        = tag_reg;
        lacc_next       = lacc_reg;
        lleft_next      = lleft_reg;
        cleft_next      = cleft_reg;
        bc_next         = bc_reg;
        depth_next      = depth_reg;
        err_next        = err_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        lvl_next        = lvl_reg;
        stk_we          = 1'b0;
        stk_wdata       = '0;
        q_push          = 1'b0;
        q_wdata         = pend_reg;
        q_wdata.last    = 1'b0;
        hd_go           = 1'b0;
        hd_indef        = 1'b0;
        hd_len          = '0;
        fail_go         = 1'b0;
        fail_code       = ERR_NONE;

        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next  = in_data.in_byte;
                    state_next = F_EXEC;
                    if (in_data.frame_start)
                    begin
                        phase_next = PH_IDENT;
                        class_next = '0;
                        cons_next  = 1'b0;
                        tag_next   = '0;
                        lacc_next  = '0;
                        lleft_next = '0;
                        cleft_next = '0;
                        bc_next    = '0;
                        depth_next = '0;
                        err_next   = 1'b0;
                    end
                end
            end
            F_EXEC:
            begin
                state_next = F_IDLE;
                if (err_reg)
                begin
                    state_next = F_IDLE;
                end
                else if (phase_reg != PH_DATA && has_lim && top.pos == bc_reg)
                begin
                    // header byte where the enclosing level has no room left
                    fail_go   = 1'b1;
                    fail_code = ERR_OVERRUN;
                end
                else
                begin
                    bc_next = bc_inc;
                    case (phase_reg)
                        PH_IDENT:
                        begin
                            class_next = byte_reg[7:6];
                            cons_next  = byte_reg[5];
                            if (byte_reg[4:0] == 5'h1f)
                            begin
                                tag_next   = '0;
                                phase_next = PH_TAGX;
                            end
                            else
                            begin
                                tag_next   = TAG_BITS'(byte_reg[4:0]);
                                phase_next = PH_LEN;
                            end
                        end
                        PH_TAGX:
                        begin
                            tag_next = tag_or;
                            if (byte_reg[7])
                            begin
                                if (tag_or[TAG_BITS-1 -: 7] != '0)
                                begin
                                    fail_go   = 1'b1;
                                    fail_code = ERR_TAG_OVF;
                                end
                                else
                                begin
                                    tag_next = tag_or << 7;
                                end
                            end
                            else
                            begin
                                phase_next = PH_LEN;
                            end
                        end
                        PH_LEN:
                        begin
                            if (byte_reg[7])
                            begin
                                if (byte_reg[6:0] > 7'(lim_oct))
                                begin
                                    fail_go   = 1'b1;
                                    fail_code = ERR_LEN_LONG;
                                end
                                else if (byte_reg[6:0] == '0)
                                begin
                                    hd_go    = 1'b1;
                                    hd_indef = 1'b1;
                                end
                                else
                                begin
                                    lacc_next  = '0;
                                    lleft_next = byte_reg[2:0];
                                    phase_next = PH_LENX;
                                end
                            end
                            else
                            begin
                                hd_go  = 1'b1;
                                hd_len = 32'(byte_reg);
                            end
                        end
                        PH_LENX:
                        begin
                            lacc_next  = lacc_shift;
                            lleft_next = lleft_reg - 3'd1;
                            if (lleft_reg == 3'd1)
                            begin
                                hd_go  = 1'b1;
                                hd_len = lacc_shift;
                            end
                        end
                        default:
                        begin
                            pend_next = mk_ev(EV_CONTENT, class_reg, cons_reg, tag_reg,
                                              lacc_reg, 1'b0, depth_reg, byte_reg,
                                              ERR_NONE);
                            pend_valid_next = 1'b1;
                            cleft_next      = cleft_reg - 32'd1;
                            if (cleft_reg == 32'd1)
                            begin
                                phase_next = PH_IDENT;
                                lvl_next   = depth_reg;
                                state_next = F_END;
                            end
                            else
                            begin
                                state_next = F_FLUSH;
                            end
                        end
                    endcase

                    if (hd_go)
                    begin
                        if (!cons_reg && hd_indef)
                        begin
                            fail_go   = 1'b1;
                            fail_code = ERR_IND_PRIM;
                        end
                        else if (has_lim && !hd_indef && hd_len > (top.pos - bc_inc))
                        begin
                            fail_go   = 1'b1;
                            fail_code = ERR_OVERRUN;
                        end
                        else if (depth_nz && top.ind && class_reg == 2'd0 && tag_reg == '0)
                        begin
                            // end of contents closes the indefinite level
                            depth_next = depth_reg - 1'b1;
                            lvl_next   = depth_reg - 1'b1;
                            phase_next = PH_IDENT;
                            state_next = F_END;
                        end
                        else if (cons_reg && (hd_indef || hd_len != '0))
                        begin
                            if (depth_reg >= DEPTH_W'(MAX_DEPTH))
                            begin
                                fail_go   = 1'b1;
                                fail_code = ERR_DEEP;
                            end
                            else
                            begin
                                pend_next = mk_ev(EV_HEADER, class_reg, 1'b1, tag_reg,
                                                  hd_indef ? 32'd0 : hd_len, hd_indef,
                                                  depth_reg, 8'd0, ERR_NONE);
                                pend_valid_next = 1'b1;
                                stk_we = 1'b1;
                                if (hd_indef)
                                begin
                                    stk_wdata.ind     = 1'b1;
                                    stk_wdata.has_lim = has_lim;
                                    stk_wdata.pos     = top.pos;
                                end
                                else
                                begin
                                    stk_wdata.ind     = 1'b0;
                                    stk_wdata.has_lim = 1'b1;
                                    stk_wdata.pos     = bc_inc + hd_len;
                                end
                                depth_next = depth_reg + 1'b1;
                                phase_next = PH_IDENT;
                                state_next = F_FLUSH;
                            end
                        end
                        else if (hd_len == '0)
                        begin
                            pend_next = mk_ev(EV_HEADER, class_reg, cons_reg, tag_reg,
                                              32'd0, 1'b0, depth_reg, 8'd0, ERR_NONE);
                            pend_valid_next = 1'b1;
                            lvl_next   = depth_reg;
                            phase_next = PH_IDENT;
                            state_next = F_END;
                        end
                        else
                        begin
                            pend_next = mk_ev(EV_HEADER, class_reg, cons_reg, tag_reg,
                                              hd_len, 1'b0, depth_reg, 8'd0, ERR_NONE);
                            pend_valid_next = 1'b1;
                            lacc_next  = hd_len;
                            cleft_next = hd_len;
                            phase_next = PH_DATA;
                            state_next = F_FLUSH;
                        end
                    end
                end

                if (fail_go)
                begin
                    pend_next = mk_ev(EV_ERROR, 2'd0, 1'b0, '0, 32'd0, 1'b0,
                                      depth_reg, 8'd0, fail_code);
                    pend_valid_next = 1'b1;
                    err_next        = 1'b1;
                    stk_we          = 1'b0;
                    depth_next      = depth_reg;
                    state_next      = F_FLUSH;
                end
            end
            F_END:
            begin
                if (!pend_valid_reg || !q_stat.full)
                begin
                    q_push          = pend_valid_reg;
                    pend_next       = mk_ev(EV_END, 2'd0, 1'b0, '0, 32'd0, 1'b0,
                                            lvl_reg, 8'd0, ERR_NONE);
                    pend_valid_next = 1'b1;
                    state_next      = F_CASC;
                end
            end
            F_CASC:
            begin
                // one enclosing level closed per cycle while the queue is not full
                if (casc_ok)
                begin
                    if (!q_stat.full)
                    begin
                        q_push     = 1'b1;
                        depth_next = depth_reg - 1'b1;
                        pend_next  = mk_ev(EV_END, 2'd0, 1'b0, '0, 32'd0, 1'b0,
                                           depth_reg - 1'b1, 8'd0, ERR_NONE);
                    end
                end
                else
                begin
                    state_next = F_FLUSH;
                end
            end
            F_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = F_IDLE;
                end
                else if (!q_stat.full)
                begin
                    q_push          = 1'b1;
                    q_wdata.last    = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            phase_reg      <= PH_IDENT;
            class_reg      <= '0;
            cons_reg       <= 1'b0;
            tag_reg        <= '0;
            lacc_reg       <= '0;
            lleft_reg      <= '0;
            cleft_reg      <= '0;
            bc_reg         <= '0;
            depth_reg      <= '0;
            err_reg        <= 1'b0;
            cfg_reg        <= LEN_OCT_RESET;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            class_reg      <= class_next;
            cons_reg       <= cons_next;
            tag_reg        <= tag_next;
            lacc_reg       <= lacc_next;
            lleft_reg      <= lleft_next;
            cleft_reg      <= cleft_next;
            bc_reg         <= bc_next;
            depth_reg      <= depth_next;
            err_reg        <= err_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        pend_reg <= pend_next;
        lvl_reg  <= lvl_next;
        if (stk_we)
        begin
            stack_mem[IDX_W'(depth_reg)] <= stk_wdata;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/btlv_queue.sv -----
// short event queue between the front and back parts
// depends on btlv_pkg
`timescale 1ns / 1ps
`default_nettype none

module btlv_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire btlv_pkg::btlv_out_t   wdata,
    input  wire logic                  pop,
    output btlv_pkg::btlv_out_t        rdata,
    output btlv_pkg::btlv_qstat_t      stat
);
    import btlv_pkg::*;

    btlv_out_t            mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;

    assign rdata      = mem[rd_ptr_reg];
    assign stat.full  = cnt_reg == Q_CNT_W'(Q_DEPTH);
    assign stat.empty = cnt_reg == '0;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/btlv_back.sv -----
// back part: takes queued events, clears fields unused by each kind, holds the result
// in an output register; depends on btlv_pkg
`timescale 1ns / 1ps
`default_nettype none

module btlv_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire btlv_pkg::btlv_out_t   q_rdata,
    input  wire btlv_pkg::btlv_qstat_t q_stat,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output btlv_pkg::btlv_out_t        out_data
);
    import btlv_pkg::*;

    logic      valid_reg;
    btlv_out_t data_reg, fmt;

    always_comb
    begin
        fmt = q_rdata;
        case (q_rdata.event_kind)
            EV_HEADER:
            begin
                fmt.data_byte  = '0;
                fmt.error_code = ERR_NONE;
            end
            EV_CONTENT:
            begin
                fmt.indefinite = 1'b0;
                fmt.error_code = ERR_NONE;
            end
            EV_END:
            begin
                fmt.tag_class      = '0;
                fmt.constructed    = 1'b0;
                fmt.tag_number     = '0;
                fmt.content_length = '0;
                fmt.indefinite     = 1'b0;
                fmt.data_byte      = '0;
                fmt.error_code     = ERR_NONE;
            end
            default:
            begin
                fmt.tag_class      = '0;
                fmt.constructed    = 1'b0;
                fmt.tag_number     = '0;
                fmt.content_length = '0;
                fmt.indefinite     = 1'b0;
                fmt.data_byte      = '0;
            end
        endcase
    end

    assign q_pop     = !q_stat.empty && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || !out_stall)
        begin
            valid_reg <= !q_stat.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            data_reg <= fmt;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ber_tlv_stream_parser.sv -----
// ber tlv stream parser, top level; uses btlv_pkg, btlv_front, btlv_queue, btlv_back
// and ber_tlv_stream_parser_macros.svh
//
// input channel in_valid/in_stall/in_data carries one stream byte per request;
// frame_start set on a byte clears the parse state before that byte is decoded.
// output channel out_valid/out_stall/out_data carries events: header, content
// byte, element end, error; last marks the final event caused by one byte.
// cfg_we/cfg_wdata write max_len_octets (4 after reset); the user must write it only
// while the block is idle; the block does not enforce this. the front decoder takes
// one byte at a time and no new byte until every event of the last one is queued;
// a byte that ends an element also passes the END and CASC states, which close each
// further nesting level it ends. an accepted byte is held in the byte register,
// and its events pass the pending event register, the queue and the output register.
// a four-entry queue lets the front run while out_stall holds the output
// register; once the queue fills, the front waits and in_stall stays high.
// reset clears all parse state; after an error one error event is sent and
// bytes are taken and dropped until a request with frame_start.
`timescale 1ns / 1ps
`default_nettype none
`include "ber_tlv_stream_parser_macros.svh"

module ber_tlv_stream_parser (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire btlv_pkg::btlv_in_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output btlv_pkg::btlv_out_t       out_data,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_wdata
);
    import btlv_pkg::*;

    logic         q_push;
    logic         q_pop;
    btlv_out_t    q_wdata;
    btlv_out_t    q_rdata;
    btlv_qstat_t  q_stat;
    btlv_fstat_t  f_stat;

    assign in_stall = f_stat.busy;

    btlv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid && !f_stat.busy),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_wdata   (q_wdata),
        .f_stat    (f_stat)
    );

    btlv_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    btlv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rdata   (q_rdata),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `BTLV_NEVER(a_push_when_full, q_push && q_stat.full)
    `BTLV_NEVER(a_pop_when_empty, q_pop && q_stat.empty)
    `BTLV_ASSERT(a_depth_in_range, f_stat.depth <= DEPTH_W'(MAX_DEPTH))
    `BTLV_ASSERT(a_no_push_idle, !f_stat.busy |-> !q_push)

endmodule

`default_nettype wire
